@@ hw/rtl/smlc_pkg.sv @@
package smlc_pkg;

  // Window depth default and field widths
  localparam int MAX_PATTERN_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int TAG_W           = 8;
  localparam int LINE_W          = 24;
  localparam int COL_W           = 16;
  localparam int LEN_W           = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int PAT_BYTES       = 16;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_MAX     = 24'hFFFFFF;
  localparam logic [COL_W-1:0]  COL_MAX      = 16'hFFFF;

  // Match queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } reg_index_t;

  // One match record
  typedef struct packed {
    logic [TAG_W-1:0]  file;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
  } match_t;

endpackage

@@ hw/rtl/smlc_front.sv @@
module smlc_front #(
  parameter int MAX_PATTERN = smlc_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [smlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [smlc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic [smlc_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               file_start,
  input  logic [smlc_pkg::TAG_W-1:0]         file_tag,
  output logic                               hit,
  output smlc_pkg::match_t                   hit_word
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [smlc_pkg::LEN_W-1:0] LEN_CAP = smlc_pkg::LEN_W'(MAX_PATTERN);

  // Configuration registers
  logic [smlc_pkg::LEN_W-1:0]        pattern_length;
  logic [2*smlc_pkg::CFG_DATA_W-1:0] pattern_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= smlc_pkg::LEN_W'(1);
      pattern_bytes  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smlc_pkg::REG_PATTERN_LENGTH:
          pattern_length <= cfg_data[smlc_pkg::LEN_W-1:0];
        smlc_pkg::REG_PATTERN_LOW:
          pattern_bytes[smlc_pkg::CFG_DATA_W-1:0] <= cfg_data;
        smlc_pkg::REG_PATTERN_HIGH:
          pattern_bytes[2*smlc_pkg::CFG_DATA_W-1:smlc_pkg::CFG_DATA_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position and window state
  logic [smlc_pkg::LINE_W-1:0] cur_line;
  logic [smlc_pkg::COL_W-1:0]  cur_col;
  logic [FILL_W-1:0]           fill;
  logic [smlc_pkg::BYTE_W-1:0] win_byte [MAX_PATTERN];
  logic [smlc_pkg::LINE_W-1:0] win_line [MAX_PATTERN];
  logic [smlc_pkg::COL_W-1:0]  win_col  [MAX_PATTERN];

  logic [smlc_pkg::LINE_W-1:0] base_line, line_next;
  logic [smlc_pkg::COL_W-1:0]  base_col, col_next;
  logic [FILL_W-1:0]           base_fill, fill_next;

  // Line and column of the incoming byte; file start restarts counting
  always_comb begin
    base_line = file_start ? smlc_pkg::LINE_W'(1) : cur_line;
    base_col  = file_start ? '0 : cur_col;
    base_fill = file_start ? '0 : fill;
    line_next = base_line;
    col_next  = base_col;
    if (data_byte == smlc_pkg::NEWLINE_BYTE) begin
      if (base_line != smlc_pkg::LINE_MAX) line_next = base_line + 1'b1;
      col_next = '0;
    end else if (base_col != smlc_pkg::COL_MAX) begin
      col_next = base_col + 1'b1;
    end
    fill_next = (base_fill == FILL_W'(MAX_PATTERN)) ? base_fill : base_fill + 1'b1;
  end

  // Window after this byte: entry 0 is the newest
  logic [smlc_pkg::BYTE_W-1:0] nb [MAX_PATTERN];
  logic [smlc_pkg::LINE_W-1:0] nl [MAX_PATTERN];
  logic [smlc_pkg::COL_W-1:0]  nc [MAX_PATTERN];

  always_comb begin
    nb[0] = data_byte;
    nl[0] = line_next;
    nc[0] = col_next;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      nb[j] = win_byte[j-1];
      nl[j] = win_line[j-1];
      nc[j] = win_col[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line <= smlc_pkg::LINE_W'(1);
      cur_col  <= '0;
      fill     <= '0;
    end else if (accept) begin
      cur_line <= line_next;
      cur_col  <= col_next;
      fill     <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_byte[j] <= nb[j];
        win_line[j] <= nl[j];
        win_col[j]  <= nc[j];
      end
    end
  end

  // Parallel compare: window entry j against pattern byte len-1-j
  logic [smlc_pkg::LEN_W-1:0]  len_eff;
  logic                        miss;
  logic [smlc_pkg::LINE_W-1:0] first_line;
  logic [smlc_pkg::COL_W-1:0]  first_col;

  always_comb begin
    logic [smlc_pkg::LEN_W-1:0]  pidx;
    logic [smlc_pkg::BYTE_W-1:0] pbyte;
    len_eff    = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;
    miss       = 1'b0;
    first_line = nl[0];
    first_col  = nc[0];
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx  = len_eff - smlc_pkg::LEN_W'(j) - smlc_pkg::LEN_W'(1);
      pbyte = pattern_bytes[pidx[3:0]*smlc_pkg::BYTE_W +: smlc_pkg::BYTE_W];
      if (smlc_pkg::LEN_W'(j) < len_eff && nb[j] != pbyte) miss = 1'b1;
      if (smlc_pkg::LEN_W'(j + 1) == len_eff) begin
        first_line = nl[j];
        first_col  = nc[j];
      end
    end
  end

  assign hit = accept && (len_eff != '0) && !miss &&
               (smlc_pkg::LEN_W'(fill_next) >= len_eff);
  assign hit_word.file   = file_tag;
  assign hit_word.line   = first_line;
  assign hit_word.column = first_col;

endmodule

@@ hw/rtl/smlc_queue.sv @@
module smlc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  smlc_pkg::match_t        push_word,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_ready,
  output smlc_pkg::match_t        out_word
);

  // Match storage
  smlc_pkg::match_t mem [smlc_pkg::QUEUE_DEPTH];

  logic [smlc_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [smlc_pkg::QCNT_W-1:0] count;
  logic                        pop;

  assign full = (count == smlc_pkg::QCNT_W'(smlc_pkg::QUEUE_DEPTH));
  // Move the head into the output register whenever it is free or being taken
  assign pop  = (count != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_word <= mem[rd_ptr];
  end

endmodule

@@ hw/rtl/substring_match_line_column.sv @@
// Channel  | Handshake             | Word
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_ready   | data_byte, file_start, file_tag
// output   | out_valid / out_ready | match_file, match_line, match_column
// config   | cfg_write             | cfg_index, cfg_data (no wait)
//
// One byte per cycle while the queue is not full: the window shift and the
// full pattern compare finish in the cycle the byte is taken. A match word
// reaches the output through a 4-entry queue and an output register.
// in_ready drops only while the queue is full. rst is synchronous and
// returns line 1, column 0, an empty window and a pattern length of 1.
module substring_match_line_column #(
  parameter int MAX_PATTERN = smlc_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [smlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [smlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [smlc_pkg::BYTE_W-1:0]      data_byte,
  input  logic                             file_start,
  input  logic [smlc_pkg::TAG_W-1:0]       file_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [smlc_pkg::TAG_W-1:0]       match_file,
  output logic [smlc_pkg::LINE_W-1:0]      match_line,
  output logic [smlc_pkg::COL_W-1:0]       match_column
);

  logic             accept;
  logic             hit;
  logic             full;
  smlc_pkg::match_t hit_word;
  smlc_pkg::match_t out_word;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Front: position tracking, window and compare
  smlc_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .data_byte  (data_byte),
    .file_start (file_start),
    .file_tag   (file_tag),
    .hit        (hit),
    .hit_word   (hit_word)
  );

  // Back: match queue and output register
  smlc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (hit),
    .push_word (hit_word),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign match_file   = out_word.file;
  assign match_line   = out_word.line;
  assign match_column = out_word.column;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import smlc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 9;
  localparam int PHASE_BYTES     = 110;
  localparam int LONG_LINE_BYTES = 64;
  localparam int FIXED_LENS [6]  = '{1, 2, 3, 16, 0, 31};
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_B = 8'h62;
  localparam logic [BYTE_W-1:0] CH_X = 8'h78;
  localparam logic [BYTE_W-1:0] CH_Y = 8'h79;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_e;

  // Search window mirror and queue of pending match words
  class match_scoreboard;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [BYTE_W-1:0]     win_byte [MAX_PATTERN_DEF];
    logic [LINE_W-1:0]     win_line [MAX_PATTERN_DEF];
    logic [COL_W-1:0]      win_col  [MAX_PATTERN_DEF];
    int                    win_fill;
    logic [LINE_W-1:0]     cur_line;
    logic [COL_W-1:0]      cur_col;
    logic [TAG_W-1:0]      cur_file;
    match_t                match_q [$];
    int                    errors;

    function new();
      pat_len  = LEN_W'(1);
      pat_low  = '0;
      pat_high = '0;
      foreach (win_byte[k]) begin
        win_byte[k] = '0;
        win_line[k] = '0;
        win_col[k]  = '0;
      end
      win_fill = 0;
      cur_line = LINE_W'(1);
      cur_col  = '0;
      cur_file = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_low  = value;
        REG_PATTERN_HIGH:   pat_high = value;
        default: ;
      endcase
    endfunction

    // Advance the window by one byte; queue a match word on a hit
    function void note_byte(logic [BYTE_W-1:0] b, logic start, logic [TAG_W-1:0] tag);
      logic [2*CFG_DATA_W-1:0] pat_all;
      int n;
      match_t m;
      if (start) begin
        cur_line = LINE_W'(1);
        cur_col  = '0;
        win_fill = 0;
      end
      cur_file = tag;
      if (b == NEWLINE_BYTE) begin
        if (cur_line != LINE_MAX) cur_line++;
        cur_col = '0;
      end else if (cur_col != COL_MAX) begin
        cur_col++;
      end
      for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) begin
        win_byte[k] = win_byte[k-1];
        win_line[k] = win_line[k-1];
        win_col[k]  = win_col[k-1];
      end
      win_byte[0] = b;
      win_line[0] = cur_line;
      win_col[0]  = cur_col;
      if (win_fill < MAX_PATTERN_DEF) win_fill++;
      // lengths above the window depth act as a full window
      n = (int'(pat_len) > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
      if (n == 0 || win_fill < n) return;
      pat_all = {pat_high, pat_low};
      for (int k = 0; k < n; k++) begin
        if (win_byte[n-1-k] != pat_all[8*k +: 8]) return;
      end
      m.file   = cur_file;
      m.line   = win_line[n-1];
      m.column = win_col[n-1];
      match_q.push_back(m);
    endfunction

    function void check_match(logic [TAG_W-1:0] f, logic [LINE_W-1:0] ln,
                              logic [COL_W-1:0] col);
      match_t m;
      if (match_q.size() == 0) begin
        $error("match word with none pending: file %0d line %0d column %0d", f, ln, col);
        errors++;
        return;
      end
      m = match_q.pop_front();
      if (m.file !== f) begin
        $error("match_file expected %0d actual %0d", m.file, f);
        errors++;
      end
      if (m.line !== ln) begin
        $error("match_line expected %0d actual %0d", m.line, ln);
        errors++;
      end
      if (m.column !== col) begin
        $error("match_column expected %0d actual %0d", m.column, col);
        errors++;
      end
    endfunction

    function int pending();
      return match_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [BYTE_W-1:0]      data_byte;
  logic                   file_start;
  logic [TAG_W-1:0]       file_tag;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [TAG_W-1:0]       match_file;
  logic [LINE_W-1:0]      match_line;
  logic [COL_W-1:0]       match_column;

  match_scoreboard   sb = new();
  logic [BYTE_W-1:0] pat [MAX_PATTERN_DEF];
  int                burst_left = 0;
  logic [TAG_W-1:0]  tag_now = '0;
  rx_mode_e          rx_mode = RX_OPEN;
  int                rx_left = 0;
  int                quiet_cycles = 0;

  substring_match_line_column u_top (.*);

  always #1 clk = ~clk;

  // Receiver: ready pattern switches among four modes at random
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: out_ready <= (rx_left[2:0] == 3'd0);
      default:     out_ready <= ($urandom_range(0, 24) == 0);
    endcase
  end

  // Monitor both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(data_byte, file_start, file_tag);
    if (!rst && out_valid && out_ready) sb.check_match(match_file, match_line, match_column);
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Send one byte word, then maybe idle between bursts
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic start,
                           input logic [TAG_W-1:0] tag);
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= start;
    file_tag   <= tag;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(0, 30);
    end
  endtask

  // Stop sending and wait out every pending match plus the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random pattern bytes: fully random, two-symbol, or one repeated symbol
  function automatic void pick_pattern();
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] c;
    int style;
    a = BYTE_W'($urandom);
    c = ($urandom_range(0, 3) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom);
    style = $urandom_range(0, 2);
    foreach (pat[k]) begin
      case (style)
        0:       pat[k] = BYTE_W'($urandom);
        1:       pat[k] = ($urandom_range(0, 1) == 1) ? a : c;
        default: pat[k] = a;
      endcase
    end
  endfunction

  // Program length and pattern words from pat[]; block must be idle
  task automatic set_pattern(input logic [LEN_W-1:0] len, input bit poke_spare);
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] low_word;
    logic [CFG_DATA_W-1:0] high_word;
    logic [CFG_DATA_W-1:0] spare_word;
    for (int k = 0; k < 8; k++) begin
      low_word[8*k +: 8]  = pat[k];
      high_word[8*k +: 8] = pat[k+8];
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    spare_word = {$urandom, $urandom};
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= len_word;
    sb.write_reg(REG_PATTERN_LENGTH, len_word);
    @(posedge clk);
    cfg_index <= REG_PATTERN_LOW;
    cfg_data  <= low_word;
    sb.write_reg(REG_PATTERN_LOW, low_word);
    @(posedge clk);
    cfg_index <= REG_PATTERN_HIGH;
    cfg_data  <= high_word;
    sb.write_reg(REG_PATTERN_HIGH, high_word);
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_INDEX_SPARE;
      cfg_data  <= spare_word;
      sb.write_reg(REG_INDEX_SPARE, spare_word);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] chunk [$];
    logic [LEN_W-1:0]  phase_len;
    logic              start;
    int n;
    int sent;
    int r;
    int cut;

    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_PATTERN_LENGTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    file_start = 1'b0;
    file_tag   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the pattern is a single zero byte
    push_byte(8'h00, 1'b1, 8'h00);
    push_byte(NEWLINE_BYTE, 1'b0, 8'h00);
    push_byte(8'h00, 1'b0, 8'h00);

    // "aba": overlapping hits, window flush on file start, tag change mid-file
    pick_pattern();
    pat[0] = CH_A;
    pat[1] = CH_B;
    pat[2] = CH_A;
    set_pattern(LEN_W'(3), 1'b1);
    push_byte(CH_A, 1'b1, 8'h01);
    push_byte(CH_B, 1'b0, 8'h01);
    push_byte(CH_A, 1'b0, 8'h01);
    push_byte(CH_B, 1'b0, 8'h01);
    push_byte(CH_A, 1'b0, 8'h01);
    push_byte(CH_B, 1'b1, 8'h02);
    push_byte(CH_A, 1'b0, 8'h02);
    push_byte(CH_B, 1'b0, 8'h03);
    push_byte(CH_A, 1'b0, 8'hFF);

    // Match starting on a newline reports column 0
    pick_pattern();
    pat[0] = NEWLINE_BYTE;
    pat[1] = 8'hFF;
    set_pattern(LEN_W'(2), 1'b0);
    push_byte(8'h41, 1'b1, 8'h80);
    push_byte(NEWLINE_BYTE, 1'b0, 8'h80);
    push_byte(8'hFF, 1'b0, 8'h80);

    // Zero length never matches
    foreach (pat[k]) pat[k] = '0;
    set_pattern(LEN_W'(0), 1'b1);
    push_byte(8'h00, 1'b1, 8'h7F);
    push_byte(8'h00, 1'b0, 8'h7F);

    // One line of filler with x/y pairs scattered in and a run at the end
    pick_pattern();
    pat[0] = CH_X;
    pat[1] = CH_Y;
    set_pattern(LEN_W'(2), 1'b0);
    tag_now = TAG_W'($urandom);
    for (int i = 1; i <= LONG_LINE_BYTES; i++) begin
      if (i >= LONG_LINE_BYTES - 32 || i % 16 < 2) b = (i % 2 == 0) ? CH_X : CH_Y;
      else b = BYTE_W'($urandom_range(8'h20, 8'h77));
      push_byte(b, (i == 1), tag_now);
    end

    // Random phases: mostly pattern copies, broken copies and near misses
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        6:       phase_len = LEN_W'($urandom_range(1, 8));
        7:       phase_len = LEN_W'($urandom_range(1, 16));
        8:       phase_len = LEN_W'($urandom_range(0, 31));
        default: phase_len = LEN_W'(FIXED_LENS[p]);
      endcase
      n = (phase_len == 0) ? $urandom_range(1, 4)
        : (int'(phase_len) > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(phase_len);
      pick_pattern();
      set_pattern(phase_len, ($urandom_range(0, 1) == 1));
      sent = 0;
      while (sent < PHASE_BYTES) begin
        chunk.delete();
        r = $urandom_range(0, 99);
        cut = (r < 40) ? n : (r < 60) ? $urandom_range(0, n - 1) : 0;
        for (int k = 0; k < cut; k++) chunk.push_back(pat[k]);
        if (r >= 40 && r < 60) begin
          chunk.push_back(BYTE_W'($urandom));
        end else if (r >= 60 && r < 80) begin
          repeat ($urandom_range(1, 4))
            chunk.push_back(($urandom_range(0, 1) == 1) ? pat[0] : pat[n-1]);
        end else if (r >= 80) begin
          chunk.push_back(($urandom_range(0, 4) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom));
        end
        foreach (chunk[k]) begin
          start = ($urandom_range(0, 59) == 0);
          if (start || $urandom_range(0, 79) == 0) tag_now = TAG_W'($urandom);
          push_byte(chunk[k], start, tag_now);
          sent++;
        end
      end
    end

    drain();
    if (sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
